// ===== rtl/kcl_pkg.sv =====
// Shared types, constants and reset values for the keypad code lock.
`default_nettype none

package kcl_pkg;

    localparam int MAX_DIGITS    = 8;
    localparam int ATTEMPT_LIMIT = 4;

    localparam int NUM_CODES   = 4;
    localparam int DIGIT_W     = 4;
    localparam int KEY_W       = 4;
    localparam int CODE_W      = 28;
    localparam int LEN_W       = 3;
    localparam int CODE_DIGITS = CODE_W / DIGIT_W;
    localparam int CMP_DIGITS  = (MAX_DIGITS < CODE_DIGITS) ? MAX_DIGITS : CODE_DIGITS;
    localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int ATT_W       = $clog2(ATTEMPT_LIMIT + 2);
    localparam int VERDICT_W   = 3;
    localparam int REG_IDX_W   = 3;
    localparam int CFG_DATA_W  = CODE_W;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ATT_W-1:0]   attempt_t;

    localparam key_t KEY_DIGIT_MAX = 4'd9;
    localparam key_t KEY_STAR      = 4'd10;
    localparam key_t KEY_HASH      = 4'd11;

    typedef enum logic {
        OP_KEY            = 1'b0,
        OP_CLEAR_ATTEMPTS = 1'b1
    } op_t;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_NONE     = 3'd0,
        VERDICT_REGULAR  = 3'd1,
        VERDICT_CURATOR  = 3'd2,
        VERDICT_PANIC    = 3'd3,
        VERDICT_ADMIN    = 3'd4,
        VERDICT_EMPTY_OK = 3'd5
    } verdict_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_REGULAR_CODE   = 3'd0,
        REG_REGULAR_LENGTH = 3'd1,
        REG_CURATOR_CODE   = 3'd2,
        REG_CURATOR_LENGTH = 3'd3,
        REG_PANIC_CODE     = 3'd4,
        REG_PANIC_LENGTH   = 3'd5,
        REG_ADMIN_CODE     = 3'd6,
        REG_ADMIN_LENGTH   = 3'd7
    } reg_index_t;

    // Code slots in priority order.
    localparam int SLOT_REGULAR = 0;
    localparam int SLOT_CURATOR = 1;
    localparam int SLOT_PANIC   = 2;
    localparam int SLOT_ADMIN   = 3;

    typedef struct packed {
        code_t [NUM_CODES-1:0] code;
        len_t  [NUM_CODES-1:0] len;
    } cfg_t;

    // 1111, 4202, 1234, 6969 (first digit in the lowest nibble)
    localparam code_t [NUM_CODES-1:0] CODE_RESET = {
        28'h0001111, 28'h0002024, 28'h0004321, 28'h0009696
    };
    localparam len_t LEN_RESET = 3'd4;

    typedef struct packed {
        logic fire;
        op_t  operation;
        key_t key_code;
    } step_t;

    typedef struct packed {
        count_t   entry_count;
        attempt_t attempt_count;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/kcl_ifs.sv =====
// Valid/ready channel interfaces for key requests and verdicts.
`default_nettype none

interface kcl_key_if;
    import kcl_pkg::*;

    logic valid;
    logic ready;
    logic operation;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output operation, output key_code, input ready);
    modport sink   (input valid, input operation, input key_code, output ready);
endinterface

interface kcl_verdict_if;
    import kcl_pkg::*;

    logic valid;
    logic ready;
    logic [VERDICT_W-1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

// ===== rtl/kcl_cfg_regs.sv =====
// Configuration register file: four codes and their lengths.
`default_nettype none

module kcl_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [kcl_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data,
    output kcl_pkg::cfg_t                       cfg
);
    import kcl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_REGULAR_CODE:   cfg_next.code[SLOT_REGULAR] = cfg_data[CODE_W-1:0];
                REG_REGULAR_LENGTH: cfg_next.len[SLOT_REGULAR]  = cfg_data[LEN_W-1:0];
                REG_CURATOR_CODE:   cfg_next.code[SLOT_CURATOR] = cfg_data[CODE_W-1:0];
                REG_CURATOR_LENGTH: cfg_next.len[SLOT_CURATOR]  = cfg_data[LEN_W-1:0];
                REG_PANIC_CODE:     cfg_next.code[SLOT_PANIC]   = cfg_data[CODE_W-1:0];
                REG_PANIC_LENGTH:   cfg_next.len[SLOT_PANIC]    = cfg_data[LEN_W-1:0];
                REG_ADMIN_CODE:     cfg_next.code[SLOT_ADMIN]   = cfg_data[CODE_W-1:0];
                REG_ADMIN_LENGTH:   cfg_next.len[SLOT_ADMIN]    = cfg_data[LEN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code <= CODE_RESET;
            cfg_reg.len  <= {NUM_CODES{LEN_RESET}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/kcl_code_match.sv =====
// Compares the entered digit string against one length-tagged code.
`default_nettype none

module kcl_code_match (
    input  wire kcl_pkg::code_t                       code,
    input  wire kcl_pkg::len_t                        len,
    input  wire kcl_pkg::digit_t [kcl_pkg::MAX_DIGITS-1:0] digits,
    input  wire kcl_pkg::count_t                      count,
    output logic                                      match
);
    import kcl_pkg::*;

    always_comb
    begin
        match = (COUNT_W'(len) == count);
        for (int i = 0; i < CMP_DIGITS; i++)
        begin
            if ((LEN_W'(i) < len) && (digits[i] != code[i*DIGIT_W +: DIGIT_W]))
                match = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kcl_entry.sv =====
// Entry buffer, attempt counter and verdict logic for one request.
`default_nettype none

module kcl_entry (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire kcl_pkg::step_t   step,
    input  wire kcl_pkg::cfg_t    cfg,
    output kcl_pkg::verdict_t     verdict,
    output kcl_pkg::status_t      status
);
    import kcl_pkg::*;

    digit_t [MAX_DIGITS-1:0] digits_reg;
    digit_t [MAX_DIGITS-1:0] digits_next;
    count_t                  count_reg;
    count_t                  count_next;
    attempt_t                attempt_reg;
    attempt_t                attempt_next;

    // Entry as seen by the key after the full-entry clear.
    digit_t [MAX_DIGITS-1:0] eff_digits;
    count_t                  eff_count;
    attempt_t                attempt_inc;
    logic [NUM_CODES-1:0]    match;
    verdict_t                hash_verdict;

    always_comb
    begin
        if (count_reg >= COUNT_W'(MAX_DIGITS))
        begin
            eff_digits = '0;
            eff_count  = '0;
        end
        else
        begin
            eff_digits = digits_reg;
            eff_count  = count_reg;
        end
    end

    for (genvar g = 0; g < NUM_CODES; g++)
    begin : g_match
        kcl_code_match u_match (
            .code   (cfg.code[g]),
            .len    (cfg.len[g]),
            .digits (eff_digits),
            .count  (eff_count),
            .match  (match[g])
        );
    end

    assign attempt_inc = (attempt_reg < ATT_W'(ATTEMPT_LIMIT + 1)) ?
                         attempt_reg + 1'b1 : attempt_reg;

    always_comb
    begin
        if (match[SLOT_REGULAR])
            hash_verdict = VERDICT_REGULAR;
        else if (match[SLOT_CURATOR])
            hash_verdict = VERDICT_CURATOR;
        else if (match[SLOT_PANIC])
            hash_verdict = VERDICT_PANIC;
        else if (match[SLOT_ADMIN])
            hash_verdict = VERDICT_ADMIN;
        else if (eff_count == '0)
            hash_verdict = VERDICT_EMPTY_OK;
        else
            hash_verdict = VERDICT_NONE;
        // locked out once the counter passes the limit
        if (attempt_inc > ATT_W'(ATTEMPT_LIMIT))
            hash_verdict = VERDICT_NONE;
    end

    always_comb
    begin
        digits_next  = digits_reg;
        count_next   = count_reg;
        attempt_next = attempt_reg;
        verdict      = VERDICT_NONE;
        case (step.operation)
            OP_CLEAR_ATTEMPTS:
            begin
                attempt_next = '0;
            end
            OP_KEY:
            begin
                digits_next = eff_digits;
                count_next  = eff_count;
                if (step.key_code == KEY_STAR)
                begin
                    digits_next = '0;
                    count_next  = '0;
                end
                else if (step.key_code == KEY_HASH)
                begin
                    verdict      = hash_verdict;
                    attempt_next = attempt_inc;
                    digits_next  = '0;
                    count_next   = '0;
                end
                else if (step.key_code <= KEY_DIGIT_MAX &&
                         eff_count < COUNT_W'(MAX_DIGITS))
                begin
                    for (int i = 0; i < MAX_DIGITS; i++)
                    begin
                        if (COUNT_W'(i) == eff_count)
                            digits_next[i] = step.key_code;
                    end
                    count_next = eff_count + 1'b1;
                end
            end
            default:
            begin
                attempt_next = attempt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg  <= '0;
            count_reg   <= '0;
            attempt_reg <= '0;
        end
        else if (step.fire)
        begin
            digits_reg  <= digits_next;
            count_reg   <= count_next;
            attempt_reg <= attempt_next;
        end
    end

    assign status.entry_count   = count_reg;
    assign status.attempt_count = attempt_reg;

endmodule

`default_nettype wire

// ===== rtl/keypad_code_lock.sv =====
// Keypad code lock: input register, entry/verdict logic and result register.
//
// Usage:
//   keys     - request channel (valid/ready). Each request is either a key
//              event (operation 0, key_code 0..9 digit, 10 star, 11 hash)
//              or a command that clears the attempt counter (operation 1).
//   verdicts - result channel (valid/ready). Exactly one verdict per request,
//              in request order: 0 none, 1 regular, 2 curator, 3 panic,
//              4 admin, 5 empty ok. Only hash produces a nonzero verdict.
//   cfg_*    - write-only port for the four codes and their lengths; write
//              only while no request is in flight.
// A request accepted on keys sits in the input register, where the entry
// state is read and updated, and the verdict then waits in the result
// register. Throughput is one request per cycle while verdicts does not
// stall; the entry state is updated as the request leaves the input register,
// so back-to-back keys see each other's effect.
// When verdicts stalls, the result register holds and the input register
// still takes one more request; keys.ready drops only when both are full.
// Reset clears the entry, the attempt counter and both pipeline stages, and
// loads the default codes 6969, 1234, 4202 and 1111.
`default_nettype none

module keypad_code_lock (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    kcl_key_if.sink                             keys,
    kcl_verdict_if.source                       verdicts,
    input  wire logic                           cfg_write,
    input  wire logic [kcl_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kcl_pkg::*;

    cfg_t     cfg;
    step_t    step;
    verdict_t verdict;
    status_t  status;

    logic     in_valid_reg;
    logic     in_valid_next;
    op_t      in_op_reg;
    key_t     in_key_reg;
    logic     res_valid_reg;
    logic     res_valid_next;
    verdict_t res_verdict_reg;

    logic     accept;
    logic     advance;

    kcl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance    = in_valid_reg && (!res_valid_reg || verdicts.ready);
    assign keys.ready = !in_valid_reg || advance;
    assign accept     = keys.valid && keys.ready;

    assign step.fire      = advance;
    assign step.operation = in_op_reg;
    assign step.key_code  = in_key_reg;

    kcl_entry u_entry (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .cfg     (cfg),
        .verdict (verdict),
        .status  (status)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (verdicts.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg  <= op_t'(keys.operation);
            in_key_reg <= keys.key_code;
        end
        if (advance)
            res_verdict_reg <= verdict;
    end

    assign verdicts.valid   = res_valid_reg;
    assign verdicts.verdict = res_verdict_reg;

    // Counters never run past their limits.
    a_attempt_sat: assert property (@(posedge clk) disable iff (!rst_n)
        status.attempt_count <= ATT_W'(ATTEMPT_LIMIT + 1))
        else $error("attempt counter past saturation");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        status.entry_count <= COUNT_W'(MAX_DIGITS))
        else $error("entry count past capacity");

    // Only a hash key can produce a nonzero verdict.
    a_non_hash_none: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg != OP_KEY || in_key_reg != KEY_HASH)
        |=> res_verdict_reg == VERDICT_NONE)
        else $error("verdict from a request that is not hash");

    // Once locked out, a hash stays a none verdict.
    a_lockout: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_op_reg == OP_KEY && in_key_reg == KEY_HASH &&
        status.attempt_count >= ATT_W'(ATTEMPT_LIMIT)
        |=> res_verdict_reg == VERDICT_NONE)
        else $error("verdict given past the attempt limit");

    // A request moved to the result stage is always presented.
    a_advance_valid: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> verdicts.valid)
        else $error("result lost after advance");

endmodule

`default_nettype wire

// ===== dv/keypad_code_lock_tb.sv =====
// Self-checking testbench for keypad_code_lock: key requests in, verdicts out.
`default_nettype none

module keypad_code_lock_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kcl_pkg::*;

    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef struct {
        verdict_t verdict;
        int       request_id;
    } pending_verdict_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kcl_key_if     key_ch ();
    kcl_verdict_if verdict_ch ();

    keypad_code_lock u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .keys      (key_ch),
        .verdicts  (verdict_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Lock model state
    code_t  code_val [NUM_CODES];
    len_t   code_len [NUM_CODES];
    digit_t entry [MAX_DIGITS];
    int     entry_len;
    int     attempts;

    // Staging for the next code setting
    code_t  new_code [NUM_CODES];
    len_t   new_len [NUM_CODES];

    pending_verdict_t awaited [$];
    pending_verdict_t head;
    int requests_sent;
    int burst_left;
    int errors = 0;
    int settings_used;
    int verdict_seen [6] = '{default: 0};
    int stall_left = 0;
    int run_left = 0;

    function automatic void clear_entry();
        for (int i = 0; i < MAX_DIGITS; i++)
            entry[i] = '0;
        entry_len = 0;
    endfunction

    function automatic bit code_hit(int slot);
        if (int'(code_len[slot]) != entry_len)
            return 1'b0;
        for (int i = 0; i < int'(code_len[slot]) && i < MAX_DIGITS && i < CODE_DIGITS; i++)
            if (entry[i] != code_val[slot][DIGIT_W*i +: DIGIT_W])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic verdict_t lock_predict(op_t op, key_t key);
        verdict_t v;
        v = VERDICT_NONE;
        if (op == OP_CLEAR_ATTEMPTS) begin
            attempts = 0;
        end
        else begin
            // a full entry is dropped before any key is handled
            if (entry_len >= MAX_DIGITS)
                clear_entry();
            if (key == KEY_STAR) begin
                clear_entry();
            end
            else if (key == KEY_HASH) begin
                if (code_hit(SLOT_REGULAR))
                    v = VERDICT_REGULAR;
                else if (code_hit(SLOT_CURATOR))
                    v = VERDICT_CURATOR;
                else if (code_hit(SLOT_PANIC))
                    v = VERDICT_PANIC;
                else if (code_hit(SLOT_ADMIN))
                    v = VERDICT_ADMIN;
                else if (entry_len == 0)
                    v = VERDICT_EMPTY_OK;
                if (attempts < ATTEMPT_LIMIT + 1)
                    attempts++;
                if (attempts > ATTEMPT_LIMIT)
                    v = VERDICT_NONE;
                clear_entry();
            end
            else if (key <= KEY_DIGIT_MAX && entry_len < MAX_DIGITS) begin
                entry[entry_len] = key;
                entry_len++;
            end
        end
        return v;
    endfunction

    function automatic code_t random_code();
        code_t c;
        for (int i = 0; i < CODE_DIGITS; i++)
            c[DIGIT_W*i +: DIGIT_W] = ($urandom_range(0, 19) == 0) ?
                digit_t'($urandom_range(10, 15)) : digit_t'($urandom_range(0, 9));
        return c;
    endfunction

    function automatic len_t random_len();
        return ($urandom_range(0, 9) == 0) ? len_t'(0) : len_t'($urandom_range(1, 7));
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    // Send one request, wait for it to be taken, then maybe pause the sender.
    task automatic send_key(op_t op, key_t key);
        verdict_t v;
        key_ch.valid     <= 1'b1;
        key_ch.operation <= op;
        key_ch.key_code  <= key;
        @(negedge clk);
        while (!key_ch.ready)
            @(negedge clk);
        @(posedge clk);
        v = lock_predict(op, key);
        awaited.push_back('{v, requests_sent});
        requests_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            key_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) :
                                                       $urandom_range(1, 12);
        end
    endtask

    task automatic wait_for_verdicts();
        key_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // Leaves cfg_write high; program_codes lowers it after the last write.
    task automatic write_reg(reg_index_t idx, code_t data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_REGULAR_CODE:   code_val[SLOT_REGULAR] = data;
            REG_REGULAR_LENGTH: code_len[SLOT_REGULAR] = data[LEN_W-1:0];
            REG_CURATOR_CODE:   code_val[SLOT_CURATOR] = data;
            REG_CURATOR_LENGTH: code_len[SLOT_CURATOR] = data[LEN_W-1:0];
            REG_PANIC_CODE:     code_val[SLOT_PANIC]   = data;
            REG_PANIC_LENGTH:   code_len[SLOT_PANIC]   = data[LEN_W-1:0];
            REG_ADMIN_CODE:     code_val[SLOT_ADMIN]   = data;
            REG_ADMIN_LENGTH:   code_len[SLOT_ADMIN]   = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_codes();
        write_reg(REG_REGULAR_CODE,   new_code[SLOT_REGULAR]);
        write_reg(REG_REGULAR_LENGTH, code_t'(new_len[SLOT_REGULAR]));
        write_reg(REG_CURATOR_CODE,   new_code[SLOT_CURATOR]);
        write_reg(REG_CURATOR_LENGTH, code_t'(new_len[SLOT_CURATOR]));
        write_reg(REG_PANIC_CODE,     new_code[SLOT_PANIC]);
        write_reg(REG_PANIC_LENGTH,   code_t'(new_len[SLOT_PANIC]));
        write_reg(REG_ADMIN_CODE,     new_code[SLOT_ADMIN]);
        write_reg(REG_ADMIN_LENGTH,   code_t'(new_len[SLOT_ADMIN]));
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic send_digits(int first, int last);
        for (int d = first; d <= last; d++)
            send_key(OP_KEY, key_t'(d));
    endtask

    // Default codes, star clear, regular match.
    task automatic test_default_codes();
        send_key(OP_KEY, key_t'(7));
        send_key(OP_KEY, KEY_STAR);
        send_key(OP_KEY, KEY_HASH);
        send_key(OP_KEY, key_t'(6));
        send_key(OP_KEY, key_t'(9));
        send_key(OP_KEY, key_t'(6));
        send_key(OP_KEY, key_t'(9));
        send_key(OP_KEY, KEY_HASH);
        wait_for_verdicts();
    endtask

    // Eight digits fill the entry; the next key, even an unused one, clears it.
    task automatic test_full_entry();
        send_digits(0, 7);
        send_key(OP_KEY, key_t'(12));
        send_key(OP_KEY, KEY_HASH);
        wait_for_verdicts();
    endtask

    task automatic test_attempt_limit();
        send_key(OP_CLEAR_ATTEMPTS, key_t'(15));
        repeat (ATTEMPT_LIMIT + 1) send_key(OP_KEY, KEY_HASH);
        send_key(OP_CLEAR_ATTEMPTS, key_t'(0));
        wait_for_verdicts();
    endtask

    // Code extremes: untypeable nibbles, zero length, maximum length.
    task automatic test_code_extremes();
        new_code[SLOT_REGULAR] = '1;
        new_len[SLOT_REGULAR]  = len_t'(7);
        new_code[SLOT_CURATOR] = '0;
        new_len[SLOT_CURATOR]  = len_t'(0);
        new_code[SLOT_PANIC]   = 28'h9999999;
        new_len[SLOT_PANIC]    = len_t'(7);
        new_code[SLOT_ADMIN]   = 28'h0000003;
        new_len[SLOT_ADMIN]    = len_t'(1);
        program_codes();
        send_key(OP_CLEAR_ATTEMPTS, KEY_HASH);
        send_key(OP_KEY, KEY_HASH);
        repeat (7) send_key(OP_KEY, key_t'(9));
        send_key(OP_KEY, KEY_HASH);
        send_key(OP_KEY, key_t'(3));
        send_key(OP_KEY, KEY_HASH);
        repeat (7) send_key(OP_KEY, key_t'(15));
        send_key(OP_KEY, KEY_HASH);
        wait_for_verdicts();
    endtask

    task automatic run_traffic(int n);
        int start_count;
        int choice;
        int slot;
        int bad_pos;
        int run_len;
        start_count = requests_sent;
        while (requests_sent - start_count < n) begin
            choice = $urandom_range(0, 99);
            if (choice < 60) begin
                // mostly a real code attempt, sometimes with one wrong digit
                if (attempts >= ATTEMPT_LIMIT - 1 && $urandom_range(0, 3) != 0)
                    send_key(OP_CLEAR_ATTEMPTS, key_t'($urandom_range(0, 15)));
                if ($urandom_range(0, 1))
                    send_key(OP_KEY, KEY_STAR);
                slot = $urandom_range(0, NUM_CODES - 1);
                bad_pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : -1;
                for (int i = 0; i < int'(code_len[slot]); i++)
                    send_key(OP_KEY, (i == bad_pos) ? key_t'($urandom_range(0, 9)) :
                                     key_t'(code_val[slot][DIGIT_W*i +: DIGIT_W]));
                if (bad_pos == 7)
                    send_key(OP_KEY, key_t'($urandom_range(0, 9)));
                send_key(OP_KEY, KEY_HASH);
            end
            else if (choice < 72) begin
                send_key(OP_CLEAR_ATTEMPTS, key_t'($urandom_range(0, 15)));
            end
            else if (choice < 90) begin
                run_len = $urandom_range(1, 11);
                repeat (run_len) send_key(OP_KEY, key_t'($urandom_range(0, 9)));
                case ($urandom_range(0, 3))
                    0, 1: send_key(OP_KEY, KEY_HASH);
                    2:    send_key(OP_KEY, KEY_STAR);
                    default: ;
                endcase
            end
            else begin
                send_key(op_t'($urandom_range(0, 1)), key_t'($urandom_range(0, 15)));
            end
        end
    endtask

    task automatic test_random_setting(int n, bit shared_codes, bit hold_midway);
        for (int s = 0; s < NUM_CODES; s++) begin
            new_code[s] = random_code();
            new_len[s]  = random_len();
        end
        // equal codes check the priority order
        if (shared_codes) begin
            new_code[SLOT_CURATOR] = new_code[SLOT_REGULAR];
            new_len[SLOT_CURATOR]  = new_len[SLOT_REGULAR];
            new_code[SLOT_ADMIN]   = new_code[SLOT_PANIC];
            new_len[SLOT_ADMIN]    = new_len[SLOT_PANIC];
        end
        program_codes();
        if (hold_midway) begin
            run_traffic(n / 2);
            wait_for_verdicts();
            run_traffic(n - n / 2);
        end
        else begin
            run_traffic(n);
        end
        wait_for_verdicts();
    endtask

    // Receiver stalls: long open runs, short choppy runs and long stalls.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            verdict_ch.ready <= 1'b0;
        end
        else if (run_left > 0) begin
            run_left--;
            verdict_ch.ready <= 1'b1;
        end
        else begin
            case ($urandom_range(0, 3))
                0: begin
                    run_left   = $urandom_range(20, 60);
                    stall_left = 0;
                end
                1: begin
                    run_left   = $urandom_range(1, 4);
                    stall_left = $urandom_range(1, 3);
                end
                2: begin
                    run_left   = 1;
                    stall_left = 1;
                end
                default: begin
                    run_left   = $urandom_range(1, 6);
                    stall_left = $urandom_range(4, 10);
                end
            endcase
            verdict_ch.ready <= 1'b1;
        end
    end

    // Inputs only change at rising edges, so the falling edge sees what the
    // next rising edge will accept.
    always @(negedge clk) begin
        if (rst_n && verdict_ch.valid && verdict_ch.ready) begin
            if (verdict_ch.verdict <= VERDICT_EMPTY_OK)
                verdict_seen[verdict_ch.verdict]++;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("verdict %0d with no request outstanding",
                                          verdict_ch.verdict));
            end
            else begin
                head = awaited.pop_front();
                if (verdict_ch.verdict !== head.verdict)
                    report_mismatch($sformatf("request %0d: verdict %0d, want %0d (%s)",
                                              head.request_id, verdict_ch.verdict,
                                              head.verdict, head.verdict.name()));
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d verdicts outstanding", awaited.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        key_ch.valid     <= 1'b0;
        key_ch.operation <= OP_KEY;
        key_ch.key_code  <= '0;
        cfg_write        <= 1'b0;
        cfg_index        <= REG_REGULAR_CODE;
        cfg_data         <= '0;
        rst_n            <= 1'b0;
        requests_sent = 0;
        settings_used = 1;
        burst_left    = 4;
        for (int s = 0; s < NUM_CODES; s++) begin
            code_val[s] = CODE_RESET[s];
            code_len[s] = LEN_RESET;
        end
        clear_entry();
        attempts = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_codes();
        test_full_entry();
        test_attempt_limit();
        test_code_extremes();
        test_random_setting(120, 1'b0, 1'b0);
        test_random_setting(120, 1'b1, 1'b1);
        test_random_setting(120, 1'b0, 1'b0);
        test_random_setting(120, 1'b0, 1'b0);

        wait_for_verdicts();
        repeat (10) @(posedge clk);
        $display("%0d requests checked across %0d code settings", requests_sent,
                 settings_used);
        $display("verdicts: none %0d regular %0d curator %0d panic %0d admin %0d empty %0d",
                 verdict_seen[VERDICT_NONE], verdict_seen[VERDICT_REGULAR],
                 verdict_seen[VERDICT_CURATOR], verdict_seen[VERDICT_PANIC],
                 verdict_seen[VERDICT_ADMIN], verdict_seen[VERDICT_EMPTY_OK]);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
